// ===== hw/rtl/m3i_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared widths, types and the cofactor index table of the 3x3 inverse unit.
// ----------------------------------------------------------------------------
package m3i_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int AW  = 2 * W + 1;        // adjugate entry, signed
  localparam int DT  = 3 * W + 3;        // determinant, signed
  localparam int QB  = W + 1;            // quotient bits per lane
  localparam int SH  = 2 * F + 1;        // numerator shift
  localparam int RW  = DT + 1 + QB;      // divider working width
  localparam int CW  = $clog2(QB);       // bit counter
  localparam int QDEPTH = 8;
  localparam int QAW = $clog2(QDEPTH);
  localparam int PCW = QAW + 1;

  typedef struct packed {
    logic [8:0][AW-1:0] adj;
    logic [DT-1:0]      dmag;
    logic               det_neg;
    logic               singular;
  } m3i_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } m3i_bstate_t;

  // adjugate entry k = e[p]*e[q] - e[s]*e[t], packed as {p, q, s, t}
  function automatic logic [15:0] adj_sel(input int k);
    logic [15:0] r;
    case (k)
      0: r = {4'd4, 4'd8, 4'd5, 4'd7};
      1: r = {4'd7, 4'd2, 4'd8, 4'd1};
      2: r = {4'd1, 4'd5, 4'd2, 4'd4};
      3: r = {4'd5, 4'd6, 4'd3, 4'd8};
      4: r = {4'd8, 4'd0, 4'd6, 4'd2};
      5: r = {4'd2, 4'd3, 4'd0, 4'd5};
      6: r = {4'd3, 4'd7, 4'd4, 4'd6};
      7: r = {4'd6, 4'd1, 4'd7, 4'd0};
      8: r = {4'd0, 4'd4, 4'd1, 4'd3};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/matrix3x3_inverse_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_unit
// Inverse of a signed Q16.16 3x3 matrix by adjugate over determinant.
// ----------------------------------------------------------------------------
// A matrix word is taken on a clock edge with start high and busy low. The
// front pipeline takes one matrix per cycle while busy is low and forms
// the adjugate, the exact determinant and the singular test, then parks the
// word in an eight-deep queue. The back end pulls one word at a time: a
// singular matrix is popped once the back end is idle and its all-zero
// result appears the cycle after that pop; any other matrix runs a nine-lane
// restoring divider one quotient bit per cycle, and that divider sets the
// sustained rate. With the back end idle, nine matrices are taken
// back to back before busy first rises (more when some are singular). Each
// result appears for exactly one cycle with done high and cannot be held
// off, so the consumer must take it then. Elements are rounded to nearest
// (ties away from zero) and clipped to the Q16.16 range, with saturated
// flagging any clip. singular_threshold (cfg_wdata) must only change while
// no matrix is in flight.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we,
  input  logic [15:0]                   cfg_wdata,
  input  logic signed [m3i_pkg::W-1:0]  a00,
  input  logic signed [m3i_pkg::W-1:0]  a01,
  input  logic signed [m3i_pkg::W-1:0]  a02,
  input  logic signed [m3i_pkg::W-1:0]  a10,
  input  logic signed [m3i_pkg::W-1:0]  a11,
  input  logic signed [m3i_pkg::W-1:0]  a12,
  input  logic signed [m3i_pkg::W-1:0]  a20,
  input  logic signed [m3i_pkg::W-1:0]  a21,
  input  logic signed [m3i_pkg::W-1:0]  a22,
  output logic                          done,
  output logic signed [m3i_pkg::W-1:0]  inv00,
  output logic signed [m3i_pkg::W-1:0]  inv01,
  output logic signed [m3i_pkg::W-1:0]  inv02,
  output logic signed [m3i_pkg::W-1:0]  inv10,
  output logic signed [m3i_pkg::W-1:0]  inv11,
  output logic signed [m3i_pkg::W-1:0]  inv12,
  output logic signed [m3i_pkg::W-1:0]  inv20,
  output logic signed [m3i_pkg::W-1:0]  inv21,
  output logic signed [m3i_pkg::W-1:0]  inv22,
  output logic                          singular,
  output logic                          saturated
);

  localparam int PCW = m3i_pkg::PCW;

  logic [15:0]                  singular_threshold;
  logic [PCW-1:0]               pending;   // words in the front pipe or queue
  logic                         accept;
  logic [8:0][m3i_pkg::W-1:0]   elem;
  logic [8:0][m3i_pkg::W-1:0]   inv;
  logic                         q_push;
  logic                         q_pop;
  logic                         q_empty;
  m3i_pkg::m3i_entry_t          q_in;
  m3i_pkg::m3i_entry_t          q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      singular_threshold <= '0;
    end else if (cfg_we) begin
      singular_threshold <= cfg_wdata;
    end
  end

  // credit count: a slot is reserved on accept and freed when the back end pops
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + PCW'(accept) - PCW'(q_pop);
    end
  end

  assign busy   = (pending == PCW'(m3i_pkg::QDEPTH));
  assign accept = start && !busy;
  assign elem   = {a22, a21, a20, a12, a11, a10, a02, a01, a00};

  m3i_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .elem      (elem),
    .thr       (singular_threshold),
    .push      (q_push),
    .push_data (q_in)
  );

  m3i_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  m3i_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .head      (q_head),
    .pop       (q_pop),
    .done      (done),
    .inv       (inv),
    .singular  (singular),
    .saturated (saturated)
  );

  assign inv00 = inv[0];
  assign inv01 = inv[1];
  assign inv02 = inv[2];
  assign inv10 = inv[3];
  assign inv11 = inv[4];
  assign inv12 = inv[5];
  assign inv20 = inv[6];
  assign inv21 = inv[7];
  assign inv22 = inv[8];

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= PCW'(m3i_pkg::QDEPTH))
    else $error("credit count above queue depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (done && singular) |-> (!saturated && inv == '0))
    else $error("singular result not cleared");

endmodule

// ===== hw/rtl/m3i_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_front
// Pipelined adjugate, determinant and singular test; one matrix per cycle.
// ----------------------------------------------------------------------------
module m3i_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [8:0][m3i_pkg::W-1:0]    elem,
  input  logic [15:0]                   thr,
  output logic                          push,
  output m3i_pkg::m3i_entry_t           push_data
);

  localparam int W  = m3i_pkg::W;
  localparam int F  = m3i_pkg::F;
  localparam int AW = m3i_pkg::AW;
  localparam int DT = m3i_pkg::DT;
  localparam logic [DT:0] HALF = (DT+1)'(1) << (2 * F - 1);

  logic [5:0] vld;

  logic signed [2*W-1:0]  prod_a [9];
  logic signed [2*W-1:0]  prod_b [9];
  logic signed [AW-1:0]   adj2 [9];
  logic signed [AW-1:0]   adj3 [9];
  logic signed [AW-1:0]   adj4 [9];
  logic signed [AW-1:0]   adj5 [9];
  logic signed [AW-1:0]   adj6 [9];
  logic signed [W-1:0]    e1 [3];
  logic signed [W-1:0]    e2 [3];
  logic signed [2*W:0]    plo [3];
  logic signed [2*W:0]    phi [3];
  logic signed [DT-1:0]   term [3];
  logic signed [DT-1:0]   det5;
  logic [DT-1:0]          dmag6;
  logic                   neg6;
  logic [DT:0]            rsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], in_valid};
    end
  end

  genvar k, j;
  generate
    for (k = 0; k < 9; k++) begin : g_adj
      localparam logic [15:0] SEL = m3i_pkg::adj_sel(k);
      always_ff @(posedge clk) begin
        prod_a[k] <= $signed(elem[SEL[15:12]]) * $signed(elem[SEL[11:8]]);
        prod_b[k] <= $signed(elem[SEL[7:4]]) * $signed(elem[SEL[3:0]]);
        adj2[k]   <= prod_a[k] - prod_b[k];
        adj3[k]   <= adj2[k];
        adj4[k]   <= adj3[k];
        adj5[k]   <= adj4[k];
        adj6[k]   <= adj5[k];
      end
    end
    for (j = 0; j < 3; j++) begin : g_det
      always_ff @(posedge clk) begin
        e1[j]   <= $signed(elem[j]);
        e2[j]   <= e1[j];
        plo[j]  <= e2[j] * $signed({1'b0, adj2[3*j][W-1:0]});
        phi[j]  <= e2[j] * $signed(adj2[3*j][AW-1:W]);
        term[j] <= (DT'(phi[j]) <<< W) + DT'(plo[j]);
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    det5  <= term[0] + term[1] + term[2];
    neg6  <= det5[DT-1];
    dmag6 <= det5[DT-1] ? DT'(-det5) : DT'(det5);
  end

  // determinant magnitude rounded half up to the Q format
  assign rsum = {1'b0, dmag6} + HALF;

  always_comb begin
    push = vld[5];
    for (int i = 0; i < 9; i++) begin
      push_data.adj[i] = adj6[i];
    end
    push_data.dmag     = dmag6;
    push_data.det_neg  = neg6;
    push_data.singular = (rsum[DT:2*F] <= (DT+1-2*F)'(thr));
  end

endmodule

// ===== hw/rtl/m3i_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_queue
// Short word queue between the front pipeline and the divider.
// ----------------------------------------------------------------------------
module m3i_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  m3i_pkg::m3i_entry_t  push_data,
  input  logic                 pop,
  output logic                 empty,
  output m3i_pkg::m3i_entry_t  head
);

  localparam int QAW = m3i_pkg::QAW;
  localparam int PCW = m3i_pkg::PCW;

  m3i_pkg::m3i_entry_t slot [m3i_pkg::QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [PCW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + PCW'(push) - PCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

  assign empty = (count == '0);
  assign head  = slot[rd_ptr];

endmodule

// ===== hw/rtl/m3i_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_back
// Nine-lane restoring divider, rounding, saturation and result register.
// ----------------------------------------------------------------------------
module m3i_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          empty,
  input  m3i_pkg::m3i_entry_t           head,
  output logic                          pop,
  output logic                          done,
  output logic [8:0][m3i_pkg::W-1:0]    inv,
  output logic                          singular,
  output logic                          saturated
);

  localparam int W  = m3i_pkg::W;
  localparam int AW = m3i_pkg::AW;
  localparam int QB = m3i_pkg::QB;
  localparam int SH = m3i_pkg::SH;
  localparam int RW = m3i_pkg::RW;
  localparam int CW = m3i_pkg::CW;
  localparam logic [QB-1:0] POSMAX = QB'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [QB-1:0] NEGMAX = QB'(64'd1 << (W - 1));

  m3i_pkg::m3i_bstate_t state, state_next;

  logic [RW-1:0] num [9];
  logic [QB-1:0] qt  [9];
  logic [8:0]    ovf;
  logic [8:0]    neg;
  logic [RW-1:0] dv;
  logic [CW-1:0] cnt;
  logic          load;

  logic [AW-1:0] absadj [9];
  logic [RW-1:0] nload  [9];
  logic [W-1:0]  res    [9];
  logic [8:0]    sat;

  always_comb begin
    state_next = state;
    case (state)
      m3i_pkg::BK_IDLE: if (!empty && !head.singular) state_next = m3i_pkg::BK_DIV;
      m3i_pkg::BK_DIV:  if (cnt == '0) state_next = m3i_pkg::BK_DONE;
      m3i_pkg::BK_DONE: state_next = m3i_pkg::BK_IDLE;
      default:          state_next = m3i_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop  = (state == m3i_pkg::BK_IDLE) && !empty;
    load = pop && !head.singular;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= m3i_pkg::BK_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (pop && head.singular) || (state == m3i_pkg::BK_DONE);
    end
  end

  genvar k;
  generate
    for (k = 0; k < 9; k++) begin : g_lane
      logic          negf;
      logic [QB-1:0] lim;
      logic [QB-1:0] mag;
      always_comb begin
        absadj[k] = head.adj[k][AW-1] ? AW'(-head.adj[k]) : head.adj[k];
        nload[k]  = (RW'(absadj[k]) << SH) + RW'(head.dmag);
        negf      = neg[k] && (ovf[k] || (qt[k] != '0));
        lim       = negf ? NEGMAX : POSMAX;
        sat[k]    = ovf[k] || (qt[k] > lim);
        mag       = sat[k] ? lim : qt[k];
        res[k]    = negf ? W'(-mag) : mag[W-1:0];
      end
      always_ff @(posedge clk) begin
        if (load) begin
          num[k] <= nload[k];
          ovf[k] <= nload[k] >= (RW'(head.dmag) << (QB + 1));
          neg[k] <= head.adj[k][AW-1] ^ head.det_neg;
          qt[k]  <= '0;
        end else if (state == m3i_pkg::BK_DIV) begin
          if (num[k] >= dv) begin
            num[k] <= num[k] - dv;
            qt[k]  <= {qt[k][QB-2:0], 1'b1};
          end else begin
            qt[k]  <= {qt[k][QB-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (load) begin
      dv  <= RW'(head.dmag) << QB;
      cnt <= CW'(QB - 1);
    end else if (state == m3i_pkg::BK_DIV) begin
      dv  <= dv >> 1;
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.singular) begin
      inv       <= '0;
      singular  <= 1'b1;
      saturated <= 1'b0;
    end else if (state == m3i_pkg::BK_DONE) begin
      for (int i = 0; i < 9; i++) begin
        inv[i] <= res[i];
      end
      singular  <= 1'b0;
      saturated <= |sat;
    end
  end

endmodule
